FILE: hw/rtl/ukl_pkg.sv
// ----------------------------------------------------------------------------
// ukl_pkg
// shared types and codes for the unsorted key list core
// ----------------------------------------------------------------------------
package ukl_pkg;

  localparam logic [2:0] OP_PUT        = 3'd0;
  localparam logic [2:0] OP_FIND       = 3'd1;
  localparam logic [2:0] OP_DELETE     = 3'd2;
  localparam logic [2:0] OP_RESET_ITER = 3'd3;
  localparam logic [2:0] OP_NEXT       = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] key;
  } ukl_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] value_out;
    logic [5:0]  count;
    logic        full_res;
    logic [1:0]  status;
  } ukl_out_t;

  typedef struct packed {
    logic compare;
    logic shift_put;
    logic shift_del;
  } ukl_cell_ctrl_t;

endpackage

FILE: hw/rtl/ukl_cell.sv
// ----------------------------------------------------------------------------
// ukl_cell
// one list slot: holds a key, compares it, and shifts toward either neighbor
// ----------------------------------------------------------------------------
module ukl_cell #(
  parameter int INDEX = 0,
  parameter int SW    = 32,
  parameter int CNT_W = 6
) (
  input  logic                    clk,
  input  ukl_pkg::ukl_cell_ctrl_t ctrl,
  input  logic [SW-1:0]           cmp_key,
  input  logic [SW-1:0]           left_key,
  input  logic [SW-1:0]           right_key,
  input  logic [CNT_W-1:0]        count,
  input  logic [CNT_W-1:0]        cursor,
  input  logic                    seen_in,
  output logic                    seen_out,
  output logic [SW-1:0]           key,
  output logic [SW-1:0]           rd_data
);
  import ukl_pkg::*;

  logic valid;
  logic hit;
  logic sel;

  assign valid = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      hit <= valid && (key == cmp_key);
      sel <= valid && (cursor == CNT_W'(INDEX));
    end
  end

  // put moves everything one slot away from the head, delete closes the gap
  always_ff @(posedge clk) begin
    if (ctrl.shift_put) begin
      key <= left_key;
    end else if (ctrl.shift_del && (seen_in || hit)) begin
      key <= right_key;
    end
  end

  assign seen_out = seen_in | hit;
  assign rd_data  = sel ? key : '0;

endmodule

FILE: hw/rtl/unsorted_key_list_core.sv
// ----------------------------------------------------------------------------
// unsorted_key_list_core
// bounded unsorted key list, newest first, built as a row of key cells
// ----------------------------------------------------------------------------
// Each transaction carries an op (put, find, delete, reset iterator, next,
// clear) and a key, and returns exactly one result with found flag, value,
// length after the op, full flag and status. One item is worked at a time:
// it is taken in the idle cycle, every cell compares its key against the
// item in the next cycle, and the cells shift and the result is written to
// the output register in the apply state that follows. A new item is taken
// while a finished result still waits in the output register; the apply
// step holds until that register is free. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module unsorted_key_list_core #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ukl_pkg::ukl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ukl_pkg::ukl_out_t out_data
);
  import ukl_pkg::*;

  localparam int SW    = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t            state;
  state_t            state_next;
  logic [2:0]        op;
  logic [SW-1:0]     key;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  cursor;
  logic [CNT_W-1:0]  cursor_next;
  ukl_cell_ctrl_t    ctrl;
  logic              apply_go;
  logic              out_free;
  logic              is_full;
  logic              found_any;
  logic [SW-1:0]     rd_or;
  ukl_out_t          res;

  logic [CAPACITY:0]             seen;
  logic [CAPACITY-1:0][SW-1:0]   cell_key;
  logic [CAPACITY-1:0][SW-1:0]   cell_rd;

  assign out_free  = !out_valid || out_ready;
  assign is_full   = count == CNT_W'(CAPACITY);
  assign found_any = seen[CAPACITY];
  assign in_ready  = (state == S_IDLE) && !rst;

  // cell row
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] left_key;
    logic [SW-1:0] right_key;

    if (i == 0) begin : g_head
      assign left_key = key;
    end else begin : g_body
      assign left_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_key = '0;
    end else begin : g_inner
      assign right_key = cell_key[i+1];
    end

    ukl_cell #(
      .INDEX (i),
      .SW    (SW),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmp_key   (key),
      .left_key  (left_key),
      .right_key (right_key),
      .count     (count),
      .cursor    (cursor),
      .seen_in   (seen[i]),
      .seen_out  (seen[i+1]),
      .key       (cell_key[i]),
      .rd_data   (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // controls
  always_comb begin
    apply_go       = (state == S_APPLY) && out_free;
    ctrl.compare   = state == S_CMP;
    ctrl.shift_put = apply_go && (op == OP_PUT) && !is_full;
    ctrl.shift_del = apply_go && (op == OP_DELETE) && found_any;
  end

  // result and list bookkeeping
  always_comb begin
    count_next    = count;
    cursor_next   = cursor;
    res.found     = 1'b0;
    res.value_out = '0;
    res.status    = ST_OK;
    case (op)
      OP_PUT: begin
        if (is_full) begin
          res.status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (found_any) begin
          res.found     = 1'b1;
          res.value_out = 32'(key);
        end
      end
      OP_DELETE: begin
        if (found_any) begin
          res.found  = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          res.status = ST_ABSENT;
        end
      end
      OP_RESET_ITER: begin
        cursor_next = '0;
      end
      OP_NEXT: begin
        if (cursor < count) begin
          res.value_out = 32'(rd_or);
          cursor_next   = cursor + CNT_W'(1);
        end else begin
          res.status = ST_PAST_END;
        end
      end
      OP_CLEAR: begin
        count_next  = '0;
        cursor_next = '0;
      end
      default: begin
      end
    endcase
    res.count    = 6'(count_next);
    res.full_res = count_next == CNT_W'(CAPACITY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cursor    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= in_data.op;
      key <= in_data.key[SW-1:0];
    end
    if (apply_go) begin
      out_data <= res;
    end
  end

endmodule
